/* sv/bmf3_pkg.sv */
// Shared types, sizes and divider constants for the 3x3 box mean filter.
// No dependencies; imported by box_mean_filter_3x3_top.
package bmf3_pkg;

  // Line buffer depth and derived widths.
  localparam int MAX_DIM = 1024;
  localparam int COL_W   = $clog2(MAX_DIM);
  localparam int ROW_W   = COL_W + 1;

  // Fixed field widths.
  localparam int SIZE_W  = 11;
  localparam int CH_W    = 16;
  localparam int POS_W   = 10;
  localparam int CSUM_W  = CH_W + 2;
  localparam int TOT_W   = CH_W + 4;

  // Result queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_IMAGE_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = SIZE_W'(32);

  // Reciprocal division: q = (t * mult) >> DIV_SHIFT, exact for t < 2**TOT_W.
  localparam int DIV_SHIFT = 23;
  localparam int MULT_W    = 22;

  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_code_t;

  function automatic logic [MULT_W-1:0] div_mult(div_code_t code);
    logic [MULT_W-1:0] m;
    case (code)
      DIV_BY_4: m = MULT_W'(2097152);
      DIV_BY_6: m = MULT_W'(1398102);
      DIV_BY_9: m = MULT_W'(932068);
      default:  m = '0;
    endcase
    return m;
  endfunction

  // Three channels, index 2 = red, 1 = green, 0 = blue.
  typedef logic [2:0][CH_W-1:0]   rgb_t;
  typedef logic [2:0][CSUM_W-1:0] csum3_t;
  typedef logic [2:0][TOT_W-1:0]  tot3_t;

  typedef struct packed {
    logic            opcode;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_column;
    logic             last_of_item;
    logic             last_of_frame;
  } out_item_t;

  // One pending result between the sum stage and the divide stage.
  typedef struct packed {
    tot3_t            tot;
    div_code_t        code;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             last_of_item;
    logic             last_of_frame;
  } slot_t;

endpackage

/* sv/box_mean_filter_3x3_top.sv */
// 3x3 box mean filter over a streamed square RGB image.
// Depends on bmf3_pkg for types, sizes and divider constants.

// The block takes one item per clock for as long as out_stall stays low: the
// line buffer memory is read in the transfer cycle and written back in the
// next cycle, so consecutive items never wait on each other. A result passes
// through the memory read, column sum and reciprocal divide stages and then
// leaves through an 8-entry result queue. in_stall rises only while that
// queue, counted together with the results still in the pipeline, could not
// take two more results; a row end gives two results for one item, so a
// persistently stalled output throttles the input to the output rate. Both
// line buffers share one 1024 x 96 memory with one read and one write port
// and need no clearing pass after reset. A write of image_size restarts the
// frame and must be done while the block is idle.
module box_mean_filter_3x3_top
  import bmf3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel and flush items.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // Filtered results.
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // Configuration.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] image_size_r;
  logic [ROW_W-1:0]  n_eff;
  logic              cfg_wr;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              in_fire, flushing_a, take, wrap_a;

  logic [2*3*CH_W-1:0] line_mem [MAX_DIM];
  logic [2*3*CH_W-1:0] rd_data_r;

  logic              b_valid_r;
  logic [COL_W-1:0]  b_col_r;
  logic [ROW_W-1:0]  b_row_r;
  logic              b_flush_r;
  logic              b_last_col_r;
  rgb_t              b_pix_r;

  rgb_t              upper, middle;
  csum3_t            cur;
  csum3_t            sum0_r, sum1_r;
  tot3_t             tot1, tot2;
  logic              res1, res2, vcnt3;
  slot_t             slot1, slot2;

  logic [1:0]        c_valid_r;
  slot_t             c_slot_r [2];
  out_item_t         c_item [2];

  out_item_t         fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]  cnt_r;
  logic [1:0]        push_n;
  logic              pop;
  logic [FIFO_AW+1:0] reserve;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == REG_IMAGE_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_IMAGE_SIZE) begin
      prdata = CFG_DATA_W'(image_size_r);
    end
  end

  // Sizes outside the supported range are clamped.
  always_comb begin
    if (image_size_r < SIZE_W'(2)) begin
      n_eff = ROW_W'(2);
    end else if (32'(image_size_r) > MAX_DIM) begin
      n_eff = ROW_W'(MAX_DIM);
    end else begin
      n_eff = ROW_W'(image_size_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Transfer stage: phase check, position update, line buffer read
  // ---------------------------------------------------------------------------
  assign in_fire    = in_valid && !in_stall;
  assign flushing_a = (row_r == n_eff);
  assign take       = in_fire && (in_data.opcode == flushing_a);
  assign wrap_a     = ((ROW_W'(col_r) + ROW_W'(1)) >= n_eff);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (take) begin
      if (wrap_a) begin
        col_nxt = '0;
        row_nxt = flushing_a ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= IMAGE_SIZE_RST;
      row_r        <= '0;
      col_r        <= '0;
    end else if (cfg_wr) begin
      image_size_r <= pwdata[SIZE_W-1:0];
      row_r        <= '0;
      col_r        <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Line buffer memory: upper row in the high half, middle row in the low half.
  // A column is written in the cycle after its read, and the next read of the same
  // column comes at least two items later, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (take) begin
      rd_data_r <= line_mem[col_r];
    end
    if (b_valid_r && !b_flush_r) begin
      line_mem[b_col_r] <= {middle, b_pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= take;
    end
    if (take) begin
      b_col_r      <= col_r;
      b_row_r      <= row_r;
      b_flush_r    <= flushing_a;
      b_last_col_r <= wrap_a;
      b_pix_r      <= {in_data.in_red, in_data.in_green, in_data.in_blue};
    end
  end

  // ---------------------------------------------------------------------------
  // Sum stage: column sum of the current column and the window totals
  // ---------------------------------------------------------------------------
  assign upper  = rd_data_r[2*3*CH_W-1:3*CH_W];
  assign middle = rd_data_r[3*CH_W-1:0];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (b_flush_r) begin
        cur[ch] = CSUM_W'(upper[ch]) + CSUM_W'(middle[ch]);
      end else if (b_row_r >= ROW_W'(2)) begin
        cur[ch] = CSUM_W'(b_pix_r[ch]) + CSUM_W'(middle[ch]) + CSUM_W'(upper[ch]);
      end else begin
        cur[ch] = CSUM_W'(b_pix_r[ch]) + CSUM_W'(middle[ch]);
      end
      tot1[ch] = TOT_W'(sum0_r[ch]) + TOT_W'(sum1_r[ch]) + TOT_W'(cur[ch]);
      tot2[ch] = TOT_W'(sum1_r[ch]) + TOT_W'(cur[ch]);
    end
  end

  // The window has two rows on the first and last output rows, else three.
  assign vcnt3 = !b_flush_r && (b_row_r != ROW_W'(1));
  assign res1  = (b_row_r != '0) && (b_col_r != '0);
  assign res2  = (b_row_r != '0) && b_last_col_r;

  always_comb begin
    slot1.tot           = tot1;
    slot1.row           = POS_W'(b_row_r - ROW_W'(1));
    slot1.column        = POS_W'(b_col_r - COL_W'(1));
    slot1.last_of_item  = !res2;
    slot1.last_of_frame = 1'b0;
    if (b_col_r == COL_W'(1)) begin
      slot1.code = vcnt3 ? DIV_BY_6 : DIV_BY_4;
    end else begin
      slot1.code = vcnt3 ? DIV_BY_9 : DIV_BY_6;
    end

    slot2.tot           = tot2;
    slot2.row           = POS_W'(b_row_r - ROW_W'(1));
    slot2.column        = POS_W'(b_col_r);
    slot2.last_of_item  = 1'b1;
    slot2.last_of_frame = b_flush_r;
    slot2.code          = vcnt3 ? DIV_BY_6 : DIV_BY_4;
  end

  // Column sums of the two previous columns of the window.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      sum0_r <= '0;
      sum1_r <= '0;
    end else if (b_valid_r) begin
      sum0_r <= (b_col_r == '0) ? '0 : sum1_r;
      sum1_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= '0;
    end else begin
      c_valid_r <= {b_valid_r && res2, b_valid_r && res1};
    end
    c_slot_r[0] <= slot1;
    c_slot_r[1] <= slot2;
  end

  // ---------------------------------------------------------------------------
  // Divide stage: reciprocal multiply by 1/4, 1/6 or 1/9
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [TOT_W+MULT_W-1:0] prod;
    rgb_t                    q;
    for (int s = 0; s < 2; s++) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod  = (TOT_W+MULT_W)'(c_slot_r[s].tot[ch]) *
                (TOT_W+MULT_W)'(div_mult(c_slot_r[s].code));
        q[ch] = prod[DIV_SHIFT +: CH_W];
      end
      c_item[s].out_red       = q[2];
      c_item[s].out_green     = q[1];
      c_item[s].out_blue      = q[0];
      c_item[s].out_row       = c_slot_r[s].row;
      c_item[s].out_column    = c_slot_r[s].column;
      c_item[s].last_of_item  = c_slot_r[s].last_of_item;
      c_item[s].last_of_frame = c_slot_r[s].last_of_frame;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue, up to two writes per cycle
  // ---------------------------------------------------------------------------
  assign push_n    = 2'(c_valid_r[0]) + 2'(c_valid_r[1]);
  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (c_valid_r[0]) begin
      fifo_mem[wr_ptr_r] <= c_item[0];
    end
    if (c_valid_r[1]) begin
      fifo_mem[wr_ptr_r + FIFO_AW'(c_valid_r[0])] <= c_item[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      cnt_r    <= cnt_r + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end
  end

  // Hold off input while the queue could not absorb two more results on top of
  // everything already in flight.
  assign reserve  = (FIFO_AW+2)'(cnt_r) + (FIFO_AW+2)'(push_n) +
                    ((FIFO_AW+2)'(b_valid_r) << 1);
  assign in_stall = (reserve > (FIFO_AW+2)'(FIFO_DEPTH - 2));

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ROW_W'(col_r) < n_eff)
    else $error("column position outside the image");

  a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (take && b_valid_r && !b_flush_r) |-> (col_r != b_col_r))
    else $error("line buffer read and write hit the same column");

  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r[0] && c_valid_r[1]) |-> !c_slot_r[0].last_of_item)
    else $error("first of two results marked last of item");

  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r != '0) |-> $past(b_valid_r))
    else $error("divide stage valid without a sum stage item");

endmodule

/* tb/sv/tb_box_mean_filter_3x3_top.sv */
// Self-checking testbench for box_mean_filter_3x3_top: streams frames, predicts every
// filtered pixel and compares each result transfer against the prediction.
// Depends on bmf3_pkg for the item types, widths and register index.
module tb_box_mean_filter_3x3_top;
  import bmf3_pkg::*;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] SIZE_ADDR = CFG_ADDR_W'(4 * int'(REG_IMAGE_SIZE));
  localparam int RANDOM_ITEMS   = 850;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  box_mean_filter_3x3_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Filter state as the testbench sees it.
  logic [SIZE_W-1:0] size_reg;
  rgb_t              older_line [MAX_DIM];
  rgb_t              newer_line [MAX_DIM];
  int unsigned       col_sum [2][3];
  int unsigned       cur_row;
  int unsigned       cur_col;
  out_item_t         expected_pixels [$];

  // Run bookkeeping.
  int  fail_count = 0;
  int  used_items = 0;
  int  ignored_items = 0;
  int  results_checked = 0;
  int  frames_done = 0;
  int  held_cycles = 0;
  int  quiet_cycles = 0;
  int  gap_rate = 0;
  bit  pace_out = 1'b0;
  bit  start_long_hold = 1'b0;
  int  hold_left = 0;
  int  burst_left = 0;
  int  calm_left = 0;

  function automatic int unsigned frame_size();
    if (size_reg < 2) return 2;
    if (size_reg > MAX_DIM) return MAX_DIM;
    return size_reg;
  endfunction

  function automatic void restart_frame();
    cur_row = 0;
    cur_col = 0;
    col_sum = '{default: 0};
  endfunction

  function automatic out_item_t mean_pixel(int unsigned tot[3], int unsigned cnt,
                                           int unsigned row, int unsigned col,
                                           logic frame_end);
    out_item_t p;
    p.out_red       = CH_W'(tot[2] / cnt);
    p.out_green     = CH_W'(tot[1] / cnt);
    p.out_blue      = CH_W'(tot[0] / cnt);
    p.out_row       = POS_W'(row);
    p.out_column    = POS_W'(col);
    p.last_of_item  = 1'b0;
    p.last_of_frame = frame_end;
    return p;
  endfunction

  // Advance the filter state by one accepted item and queue the pixels it completes.
  function automatic void filter_item(in_item_t item);
    int unsigned n, r, c, orow, vcnt, ch;
    int unsigned cur [3];
    int unsigned tot [3];
    logic        flushing;
    rgb_t        pix;
    out_item_t   res [$];
    n = frame_size();
    if (cur_row > n || cur_col >= n) restart_frame();
    flushing = (cur_row == n);
    if (item.opcode != flushing) begin
      ignored_items++;
      return;
    end
    used_items++;
    r = cur_row;
    c = cur_col;
    pix = {item.in_red, item.in_green, item.in_blue};

    // Vertical sum of the current column; pixel rows also shift the line buffers.
    if (!flushing) begin
      for (ch = 0; ch < 3; ch++) begin
        cur[ch] = pix[ch] + newer_line[c][ch];
        if (r >= 2) cur[ch] += older_line[c][ch];
      end
      older_line[c] = newer_line[c];
      newer_line[c] = pix;
      orow = r - 1;
      vcnt = (r == 1) ? 2 : 3;
    end else begin
      for (ch = 0; ch < 3; ch++) cur[ch] = older_line[c][ch] + newer_line[c][ch];
      orow = n - 1;
      vcnt = 2;
    end

    // The pixel one column back, then the right-edge pixel at the end of a row.
    if (r >= 1 && c >= 1) begin
      for (ch = 0; ch < 3; ch++) tot[ch] = col_sum[0][ch] + col_sum[1][ch] + cur[ch];
      res.push_back(mean_pixel(tot, vcnt * ((c == 1) ? 2 : 3), orow, c - 1, 1'b0));
    end
    if (r >= 1 && c == n - 1) begin
      for (ch = 0; ch < 3; ch++) tot[ch] = col_sum[1][ch] + cur[ch];
      res.push_back(mean_pixel(tot, vcnt * 2, orow, c, flushing));
    end
    if (res.size() > 0) res[res.size() - 1].last_of_item = 1'b1;
    foreach (res[i]) expected_pixels.push_back(res[i]);

    for (ch = 0; ch < 3; ch++) begin
      col_sum[0][ch] = (c == 0) ? 0 : col_sum[1][ch];
      col_sum[1][ch] = cur[ch];
    end

    cur_col = c + 1;
    if (cur_col >= n) begin
      cur_col = 0;
      if (flushing) begin
        restart_frame();
        frames_done++;
      end else begin
        cur_row = r + 1;
      end
    end
  endfunction

  function automatic in_item_t make_item(logic op, rgb_t v);
    in_item_t it;
    it.opcode   = op;
    it.in_red   = v[2];
    it.in_green = v[1];
    it.in_blue  = v[0];
    return it;
  endfunction

  // Random pixel, biased toward the channel extremes.
  function automatic in_item_t pixel_item();
    rgb_t v;
    int   mode;
    mode = $urandom_range(0, 9);
    foreach (v[ch]) begin
      case (mode)
        0:       v[ch] = '0;
        1:       v[ch] = '1;
        2:       v[ch] = $urandom_range(0, 1) ? '1 : CH_W'($urandom);
        default: v[ch] = CH_W'($urandom);
      endcase
    end
    return make_item(OP_PIXEL, v);
  endfunction

  function automatic in_item_t flush_item();
    rgb_t v;
    foreach (v[ch]) v[ch] = CH_W'($urandom);
    return make_item(OP_FLUSH, v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_size_word();
    int unsigned       pick;
    logic [SIZE_W-1:0] s;
    pick = $urandom_range(0, 19);
    if (pick == 0) s = '0;
    else if (pick == 1) s = SIZE_W'(1);
    else if (pick < 6) s = SIZE_W'($urandom_range(2, 3));
    else if (pick < 16) s = SIZE_W'($urandom_range(4, 10));
    else s = SIZE_W'($urandom_range(11, 24));
    return {($urandom_range(0, 1) ? 21'($urandom) : 21'd0), s};
  endfunction

  // One input transfer, with an optional gap of idle cycles in front.
  task automatic send_item(in_item_t item);
    if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_item(item);
  endtask

  // A frame of n x n pixels and n flush items, plus random stray items when noisy; stops early at stop_after pixels.
  task automatic send_frame(int unsigned n, int unsigned stop_after, bit noisy);
    for (int unsigned i = 0; i < n * n; i++) begin
      if (i == stop_after) return;
      if (noisy && $urandom_range(0, 15) == 0) send_item(flush_item());
      send_item(pixel_item());
    end
    for (int unsigned j = 0; j < n; j++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_item(pixel_item());
      send_item(flush_item());
    end
  endtask

  // Stop sending and let every expected result out before touching the register.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_transfer(input bit is_write, input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= SIZE_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_image_size();
    logic [CFG_DATA_W-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    if (rdata[SIZE_W-1:0] !== size_reg) begin
      $error("image_size: expected %0d, got %0d", size_reg, rdata[SIZE_W-1:0]);
      fail_count++;
    end
  endtask

  task automatic set_image_size(logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] rdata;
    apb_transfer(1'b1, value, rdata);
    size_reg = value[SIZE_W-1:0];
    restart_frame();
    check_image_size();
  endtask

  // Reset value of the register, then the start of a frame at that size.
  task automatic test_reset_size();
    check_image_size();
    gap_rate = 4;
    pace_out = 1'b1;
    send_frame(frame_size(), 34, 1'b0);
    wait_idle();
  endtask

  // Size 0 acts as 2: full-scale pixels, a stray item in each phase; then size 3.
  task automatic test_smallest_frames();
    rgb_t v;
    set_image_size(0);
    v = '1;
    send_item(flush_item());
    repeat (4) send_item(make_item(OP_PIXEL, v));
    send_item(make_item(OP_PIXEL, v));
    repeat (2) send_item(flush_item());
    wait_idle();
    set_image_size(3);
    for (int i = 0; i < 9; i++) begin
      v[2] = '1;
      v[1] = (i % 2 == 1) ? '1 : '0;
      v[0] = CH_W'(i * 8191);
      send_item(make_item(OP_PIXEL, v));
    end
    repeat (3) send_item(flush_item());
    wait_idle();
  endtask

  // The largest size and an oversize value that clamps to it, each with a short
  // partial frame.
  task automatic test_largest_size();
    set_image_size(MAX_DIM);
    send_frame(frame_size(), 16, 1'b0);
    wait_idle();
    set_image_size(2047);
    send_frame(frame_size(), 16, 1'b0);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_output_hold();
    set_image_size(6);
    gap_rate = 0;
    start_long_hold = 1'b1;
    send_frame(frame_size(), 36, 1'b0);
    wait_idle();
  endtask

  // Random sizes and contents, stray items, and frames cut short by a register write.
  task automatic test_random_frames();
    int          start;
    int unsigned n;
    bit          abort;
    start = used_items;
    set_image_size(random_size_word());
    while (used_items - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       gap_rate = 0;
        1:       gap_rate = 8;
        default: gap_rate = 3;
      endcase
      pace_out = ($urandom_range(0, 3) != 0);
      n = frame_size();
      abort = ($urandom_range(0, 9) == 0);
      send_frame(n, abort ? $urandom_range(0, n * n - 1) : n * n, 1'b1);
      if (abort || $urandom_range(0, 9) < 6) begin
        wait_idle();
        set_image_size(random_size_word());
      end
    end
    wait_idle();
  endtask

  // Back-to-back frames at full rate with no idling on either side.
  task automatic test_steady_stream();
    gap_rate = 0;
    pace_out = 1'b0;
    set_image_size(1);
    send_frame(frame_size(), 4, 1'b0);
    send_frame(frame_size(), 4, 1'b0);
    wait_idle();
    set_image_size(5);
    send_frame(frame_size(), 25, 1'b0);
    send_frame(frame_size(), 25, 1'b0);
    wait_idle();
  endtask

  // Receiver stall: a long hold when requested, otherwise random bursts and calm runs when pace_out is set, else none.
  always @(posedge clk) begin
    if (start_long_hold) begin
      start_long_hold = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!pace_out) begin
      out_stall <= 1'b0;
    end else begin
      if (burst_left == 0 && calm_left == 0) begin
        burst_left = $urandom_range(1, 7);
        calm_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
      end
      if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else begin
        out_stall <= 1'b0;
        calm_left--;
      end
    end
  end

  // Compare each result transfer with the oldest predicted pixel.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result at row %0d column %0d", out_data.out_row, out_data.out_column);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (out_data.out_red !== want.out_red) begin
          $error("out_red: expected %h, got %h", want.out_red, out_data.out_red);
          fail_count++;
        end
        if (out_data.out_green !== want.out_green) begin
          $error("out_green: expected %h, got %h", want.out_green, out_data.out_green);
          fail_count++;
        end
        if (out_data.out_blue !== want.out_blue) begin
          $error("out_blue: expected %h, got %h", want.out_blue, out_data.out_blue);
          fail_count++;
        end
        if (out_data.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
          fail_count++;
        end
        if (out_data.out_column !== want.out_column) begin
          $error("out_column: expected %0d, got %0d", want.out_column, out_data.out_column);
          fail_count++;
        end
        if (out_data.last_of_item !== want.last_of_item) begin
          $error("last_of_item: expected %b, got %b", want.last_of_item, out_data.last_of_item);
          fail_count++;
        end
        if (out_data.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %b, got %b", want.last_of_frame,
                 out_data.last_of_frame);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; also counts input backpressure.
  always @(posedge clk) begin
    if (in_valid && in_stall) held_cycles++;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("box_mean_filter_3x3_top test failed");
      $finish;
    end
  end

  initial begin
    size_reg = IMAGE_SIZE_RST;
    foreach (older_line[i]) older_line[i] = '0;
    foreach (newer_line[i]) newer_line[i] = '0;
    restart_frame();
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_smallest_frames();
    test_largest_size();
    test_output_hold();
    test_random_frames();
    test_steady_stream();

    $display("Run covered %0d frames, %0d items used, %0d stray items, %0d pixels checked.",
             frames_done, used_items, ignored_items, results_checked);
    $display("Sizes 0 to 2047 were written; the input was held back for %0d cycles.",
             held_cycles);
    if (fail_count == 0) begin
      $display("box_mean_filter_3x3_top test passed");
    end else begin
      $display("box_mean_filter_3x3_top test failed");
    end
    $finish;
  end

endmodule
